// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/rdte_pkg.sv =====
package rdte_pkg;

    // pipeline depth from accept to result register
    localparam int NumStages = 6;

    // status b bits
    localparam int StbBinaryBit = 2;
    localparam int Stb24hBit    = 1;
    localparam int HourPmBit    = 7;

    // hour mod 12 by reciprocal: floor(h / 12) == (h * 43) >> 9 for h < 128
    localparam int HourRecip = 43;
    localparam int HourShift = 9;
    localparam int HalfDay   = 12;

    // month term of the civil formula
    localparam int MarchCycleDays = 153;
    localparam int MonthRound     = 2;
    // floor(x / 5) == (x * 52429) >> 18 for 16-bit x
    localparam int Div5Recip = 52429;
    localparam int Div5Shift = 18;

    // year term
    localparam int YearDays    = 365;
    localparam int CenturyOne  = 100;
    localparam int CenturyTwo  = 200;
    // offset that keeps the year term non-negative for year 1999
    localparam int YearBias    = 366;
    // days from 1970-01-01 to 2000-03-01, less the bias and the day-1 offset
    localparam int DaysBase    = 10650;

    localparam int SecPerHour = 3600;
    localparam int SecPerMin  = 60;
    localparam int SecPerDay  = 86400;

    // stage 1: decoded bytes
    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [6:0] hr;
        logic [7:0] day;
        logic [7:0] mon;
        logic [7:0] yr;
        logic       pm;
        logic       h24;
    } raw_dec_t;

    // stage 2: fields ready for the date and time arithmetic
    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [6:0]  hr;
        logic [7:0]  day;
        logic [15:0] mx;
        logic [7:0]  yidx;
        logic        ywrap;
    } fld_t;

    // bcd byte to binary, nibbles above 9 left unchecked
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi10;
        hi10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
        return hi10 + {4'b0000, b[3:0]};
    endfunction

endpackage

// ===== src/rdte_field_decode.sv =====
module rdte_field_decode
    import rdte_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] raw_seconds,
    input  logic [7:0] raw_minutes,
    input  logic [7:0] raw_hours,
    input  logic [7:0] raw_day,
    input  logic [7:0] raw_month,
    input  logic [7:0] raw_year,
    input  logic [7:0] status_b,
    output fld_t       fld
);

    raw_dec_t s1_reg, s1_next;
    fld_t     s2_reg, s2_next;

    logic [12:0] hr_prod;
    logic [3:0]  hr_quot;
    logic [6:0]  hr_rem;
    logic [4:0]  hr_12h;
    logic        jan_feb;
    logic [7:0]  mp;

    // stage 1: strip pm flag, bcd decode unless binary mode
    always_comb
    begin
        s1_next.pm  = raw_hours[HourPmBit];
        s1_next.h24 = status_b[Stb24hBit];
        if (status_b[StbBinaryBit])
        begin
            s1_next.sec = raw_seconds;
            s1_next.min = raw_minutes;
            s1_next.hr  = raw_hours[6:0];
            s1_next.day = raw_day;
            s1_next.mon = raw_month;
            s1_next.yr  = raw_year;
        end
        else
        begin
            s1_next.sec = bcd_to_bin(raw_seconds);
            s1_next.min = bcd_to_bin(raw_minutes);
            s1_next.hr  = 7'(bcd_to_bin({1'b0, raw_hours[6:0]}));
            s1_next.day = bcd_to_bin(raw_day);
            s1_next.mon = bcd_to_bin(raw_month);
            s1_next.yr  = bcd_to_bin(raw_year);
        end
    end

    // stage 2: 12-hour fold, march-based month and year shift
    always_comb
    begin
        hr_prod = 13'(s1_reg.hr) * 13'(HourRecip);
        hr_quot = 4'(hr_prod >> HourShift);
        hr_rem  = s1_reg.hr - 7'(7'(hr_quot) * 7'(HalfDay));
        hr_12h  = s1_reg.pm ? 5'(hr_rem) + 5'(HalfDay) : 5'(hr_rem);

        jan_feb = (s1_reg.mon <= 8'd2);
        mp      = jan_feb ? s1_reg.mon + 8'd9 : s1_reg.mon - 8'd3;

        s2_next.sec   = s1_reg.sec;
        s2_next.min   = s1_reg.min;
        s2_next.hr    = s1_reg.h24 ? s1_reg.hr : 7'(hr_12h);
        s2_next.day   = s1_reg.day;
        s2_next.mx    = 16'(mp) * 16'(MarchCycleDays) + 16'(MonthRound);
        s2_next.yidx  = s1_reg.yr - 8'(jan_feb);
        s2_next.ywrap = jan_feb && (s1_reg.yr == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign fld = s2_reg;

endmodule

// ===== src/rdte_calendar.sv =====
module rdte_calendar
    import rdte_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  fld_t        fld,
    output logic [16:0] days
);

    logic [12:0] mday_reg, mday_next;
    logic [16:0] ydays_reg, ydays_next;
    logic [7:0]  day_reg;
    logic [16:0] days_reg, days_next;

    logic [31:0] recip_prod;
    logic [1:0]  cent;

    // stage 3: month days by reciprocal divide, biased year days
    always_comb
    begin
        recip_prod = 32'(fld.mx) * 32'(Div5Recip);
        mday_next  = 13'(recip_prod >> Div5Shift);

        if (fld.yidx >= 8'(CenturyTwo))
            cent = 2'd2;
        else if (fld.yidx >= 8'(CenturyOne))
            cent = 2'd1;
        else
            cent = 2'd0;

        if (fld.ywrap)
            ydays_next = 17'd0;
        else
            ydays_next = 17'(fld.yidx) * 17'(YearDays) + 17'(fld.yidx[7:2])
                       - 17'(cent) + 17'(YearBias);
    end

    // stage 4: day count since 1970
    always_comb
    begin
        days_next = 17'(DaysBase) + ydays_reg + 17'(mday_reg) + 17'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mday_reg  <= mday_next;
            ydays_reg <= ydays_next;
            day_reg   <= fld.day;
            days_reg  <= days_next;
        end
    end

    assign days = days_reg;

endmodule

// ===== src/rdte_clock_time.sv =====
module rdte_clock_time
    import rdte_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  fld_t        fld,
    output logic [18:0] tod
);

    logic [18:0] tod_reg, tod_next;
    logic [18:0] tod_d_reg;

    // stage 3: seconds into the day
    always_comb
    begin
        tod_next = 19'(fld.hr) * 19'(SecPerHour) + 19'(fld.min) * 19'(SecPerMin)
                 + 19'(fld.sec);
    end

    // stage 4: align with the day count
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tod_reg   <= tod_next;
            tod_d_reg <= tod_reg;
        end
    end

    assign tod = tod_d_reg;

endmodule

// ===== src/rdte_seconds_merge.sv =====
module rdte_seconds_merge
    import rdte_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] days,
    input  logic [18:0] tod,
    output logic [31:0] epoch
);

    logic [31:0] prod_reg, prod_next;
    logic [18:0] tod_reg;
    logic [31:0] epoch_reg, epoch_next;

    // stage 5: day count to seconds, wrapped to 32 bits
    always_comb
    begin
        prod_next = 32'(34'(days) * 34'(SecPerDay));
    end

    // stage 6: add time of day
    always_comb
    begin
        epoch_next = prod_reg + 32'(tod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            tod_reg   <= tod;
            epoch_reg <= epoch_next;
        end
    end

    assign epoch = epoch_reg;

endmodule

// ===== src/rtc_datetime_to_epoch.sv =====
// depth: six register stages from the accepting edge to out_valid on its result
// throughput: one transaction per cycle; the six-stage pipeline moves as a whole
// and holds in place only while the result register is full and out_ready is low
// reset: rst_n clears all stage valid bits asynchronously; data registers are not reset
module rtc_datetime_to_epoch
    import rdte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_seconds,
    input  logic [7:0]  raw_minutes,
    input  logic [7:0]  raw_hours,
    input  logic [7:0]  raw_day,
    input  logic [7:0]  raw_month,
    input  logic [7:0]  raw_year,
    input  logic [7:0]  status_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] epoch_seconds
);

`include "assert_macros.svh"

    logic                 adv;
    logic [NumStages-1:0] vld_reg, vld_next;
    fld_t                 fld;
    logic [16:0]          days;
    logic [18:0]          tod;

    // pipeline advances unless the result register is held
    assign adv       = out_ready || !vld_reg[NumStages-1];
    assign in_ready  = adv;
    assign out_valid = vld_reg[NumStages-1];
    assign vld_next  = {vld_reg[NumStages-2:0], in_valid};

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    rdte_field_decode u_decode (
        .clk         (clk),
        .en          (adv),
        .raw_seconds (raw_seconds),
        .raw_minutes (raw_minutes),
        .raw_hours   (raw_hours),
        .raw_day     (raw_day),
        .raw_month   (raw_month),
        .raw_year    (raw_year),
        .status_b    (status_b),
        .fld         (fld)
    );

    rdte_calendar u_calendar (
        .clk  (clk),
        .en   (adv),
        .fld  (fld),
        .days (days)
    );

    rdte_clock_time u_clock_time (
        .clk (clk),
        .en  (adv),
        .fld (fld),
        .tod (tod)
    );

    rdte_seconds_merge u_merge (
        .clk   (clk),
        .en    (adv),
        .days  (days),
        .tod   (tod),
        .epoch (epoch_seconds)
    );

    // an accepted transaction occupies the first stage
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_reg[0])
    // back-pressure only comes from a full, untaken result
    `ASSERT_IMPL(a_stall_source, clk, rst_n, !in_ready, out_valid && !out_ready)
    // a stall freezes every stage valid bit
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !in_ready, $stable(vld_reg))
    // a transaction in the stage before the result register reaches the output when the pipeline advances
    `ASSERT_NEXT(a_last_moves, clk, rst_n, in_ready && vld_reg[NumStages-2], out_valid)

endmodule
